/* design/trb_pkg.sv */
`default_nettype none

package trb_pkg;

  localparam int TIME_BITS     = 32;
  localparam int TAG_PORT_BITS = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_CMP
  } trb_state_t;

endpackage

`default_nettype wire

/* design/trb_item_if.sv */
`default_nettype none

interface trb_item_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      mode;
  logic signed [trb_pkg::TIME_BITS-1:0]      time_stamp;
  logic        [trb_pkg::TAG_PORT_BITS-1:0]  frame_tag;

  modport source (output valid, output mode, output time_stamp, output frame_tag,
                  input ready);
  modport sink   (input valid, input mode, input time_stamp, input frame_tag,
                  output ready);
endinterface

`default_nettype wire

/* design/trb_result_if.sv */
`default_nettype none

interface trb_result_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [trb_pkg::TIME_BITS-1:0]      out_time;
  logic        [trb_pkg::TAG_PORT_BITS-1:0]  out_tag;

  modport source (output valid, output out_time, output out_tag, input ready);
  modport sink   (input valid, input out_time, input out_tag, output ready);
endinterface

`default_nettype wire

/* design/timestamp_reorder_buffer.sv */
// channel  | modport | transaction payload
// ---------+---------+------------------------------------------
// item     | sink    | mode, time_stamp, frame_tag
// result   | source  | out_time, out_tag (evicted head entry)
//
// an insert scans from the tail toward the head, moving each stored entry with a
// later timestamp up one place, and writes the new entry into the freed slot;
// a full buffer pops the head first. one read and one write of the entry memory
// per cycle bound the shifting. a clear empties the buffer.
// rst clears the fill count, head pointer and sequencer; memory is not cleared.
// while the buffer is full, no transaction is taken as long as an earlier
// result is still held.
`default_nettype none

module timestamp_reorder_buffer #(
  parameter int DEPTH = 4,
  parameter int TAG_BITS = 16
) (
  input wire logic     clk,
  input wire logic     rst,
  trb_item_if.sink     item,
  trb_result_if.source result
);

  // stored tag width: frame_tag bits above TAG_BITS are dropped
  localparam int SW = (TAG_BITS < trb_pkg::TAG_PORT_BITS) ? TAG_BITS
                                                          : trb_pkg::TAG_PORT_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int WIDTH = trb_pkg::TIME_BITS + SW;

  // memory port between sequencer and entry store
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [WIDTH-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [WIDTH-1:0] wr_data;
  logic             pop_load;

  // output register, parts the result side from the sequencer
  logic                                 out_valid;
  logic signed [trb_pkg::TIME_BITS-1:0] out_time;
  logic [SW-1:0]                        out_tag;

  trb_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  trb_ctrl #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_mode   (item.mode),
    .in_time   (item.time_stamp),
    .in_tag    (item.frame_tag),
    .in_ready  (item.ready),
    .out_valid (out_valid),
    .pop_load  (pop_load),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // result valid: set by a head pop, dropped when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // popped head comes straight from the registered memory read
  always_ff @(posedge clk) begin
    if (pop_load) begin
      out_time <= rd_data[WIDTH-1 -: trb_pkg::TIME_BITS];
      out_tag  <= rd_data[SW-1:0];
    end
  end

  assign result.valid    = out_valid;
  assign result.out_time = out_time;
  assign result.out_tag  = trb_pkg::TAG_PORT_BITS'(out_tag);

endmodule

`default_nettype wire

/* design/trb_mem.sv */
`default_nettype none

// single-port-write, single-port-read entry store, registered read data
module trb_mem #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 48,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/trb_ctrl.sv */
`default_nettype none

// insertion sequencer over a circular buffer of sorted entries
module trb_ctrl #(
  parameter int DEPTH = 4,
  parameter int SW = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int SUMW = CW + 1,
  localparam int WIDTH = trb_pkg::TIME_BITS + SW
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  input  wire logic                                    in_mode,
  input  wire logic signed [trb_pkg::TIME_BITS-1:0]    in_time,
  input  wire logic        [trb_pkg::TAG_PORT_BITS-1:0] in_tag,
  output logic                                         in_ready,
  input  wire logic                                    out_valid,
  output logic                                         pop_load,
  output logic                                         rd_en,
  output logic [AW-1:0]                                rd_addr,
  input  wire logic [WIDTH-1:0]                        rd_data,
  output logic                                         wr_en,
  output logic [AW-1:0]                                wr_addr,
  output logic [WIDTH-1:0]                             wr_data
);

  trb_pkg::trb_state_t state, state_next;

  logic [AW-1:0]                        head;
  logic [CW-1:0]                        fill;
  logic [CW-1:0]                        k;
  logic signed [trb_pkg::TIME_BITS-1:0] t_reg;
  logic [SW-1:0]                        tag_reg;

  logic                                 full;
  logic                                 accept;
  logic                                 greater;
  logic [CW-1:0]                        k_dec;
  logic [AW-1:0]                        head_inc;
  logic signed [trb_pkg::TIME_BITS-1:0] rd_time;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] idx);
    logic [SUMW-1:0] sum;
    sum = SUMW'(base) + SUMW'(idx);
    if (sum >= SUMW'(DEPTH)) begin
      sum = sum - SUMW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full     = (fill == CW'(DEPTH));
  assign accept   = in_valid && in_ready;
  assign rd_time  = rd_data[WIDTH-1 -: trb_pkg::TIME_BITS];
  assign greater  = (rd_time > t_reg);
  assign k_dec    = k - CW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      trb_pkg::ST_IDLE: begin
        if (accept && in_mode == trb_pkg::MODE_INSERT) begin
          state_next = full ? trb_pkg::ST_POP : trb_pkg::ST_SCAN;
        end
      end
      trb_pkg::ST_POP: state_next = trb_pkg::ST_SCAN;
      trb_pkg::ST_SCAN: begin
        state_next = (k == '0) ? trb_pkg::ST_IDLE : trb_pkg::ST_CMP;
      end
      trb_pkg::ST_CMP: begin
        state_next = greater ? trb_pkg::ST_SCAN : trb_pkg::ST_IDLE;
      end
      default: state_next = trb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    pop_load = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = head;
    wr_en    = 1'b0;
    wr_addr  = phys(head, k);
    wr_data  = {t_reg, tag_reg};
    case (state)
      trb_pkg::ST_IDLE: begin
        // a pop needs the output register free
        in_ready = !(full && out_valid);
        if (in_valid && in_ready && in_mode == trb_pkg::MODE_INSERT && full) begin
          rd_en = 1'b1;
        end
      end
      trb_pkg::ST_POP: pop_load = 1'b1;
      trb_pkg::ST_SCAN: begin
        if (k == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys(head, k_dec);
        end
      end
      trb_pkg::ST_CMP: begin
        wr_en = 1'b1;
        if (greater) begin
          wr_data = rd_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trb_pkg::ST_IDLE;
      head  <= '0;
      fill  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      case (state)
        trb_pkg::ST_IDLE: begin
          if (accept) begin
            if (in_mode == trb_pkg::MODE_CLEAR) begin
              fill <= '0;
            end else begin
              k <= full ? CW'(DEPTH - 1) : fill;
            end
          end
        end
        trb_pkg::ST_POP: begin
          head <= head_inc;
          fill <= fill - CW'(1);
        end
        trb_pkg::ST_SCAN: begin
          if (k == '0) begin
            fill <= fill + CW'(1);
          end
        end
        trb_pkg::ST_CMP: begin
          if (greater) begin
            k <= k_dec;
          end else begin
            fill <= fill + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_reg   <= in_time;
      tag_reg <= in_tag[SW-1:0];
    end
  end

endmodule

`default_nettype wire
